@@ hw/rtl/okvt_pkg.sv @@
// okvt_pkg: shared widths, command and status codes, and the control/status
// structs that join the controller and the datapath of the ordered key/value table.
// no dependencies
package okvt_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int USED_W   = 5;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_UPDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic                load;     // capture key, value, position
    logic                commit;   // perform the operation, load the result
    logic                append;   // write new entry at the tail
    logic                update;   // overwrite value of the matching entry
    logic                erase;    // remove matching entry, shift later ones down
    logic                sel_pos;  // value read at position instead of match
    logic                key_en;   // result carries the read key
    logic                val_en;   // result carries the read value
    logic [STATUS_W-1:0] status;
  } okvt_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic found;
    logic full;
    logic pos_ok;
  } okvt_stat_t;

endpackage

@@ hw/rtl/okvt_ctrl.sv @@
// okvt_ctrl: two-state controller, command decode and result handshake
// depends on okvt_pkg
module okvt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [okvt_pkg::CMD_W-1:0]  in_command,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  okvt_pkg::okvt_stat_t        stat,
  output okvt_pkg::okvt_ctl_t         ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                       state_r, state_nxt;
  logic [okvt_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       accept;
  logic                       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    ctl      = '0;
    ctl.load = accept;
    if (state_r == S_EXEC && slot_free) begin
      ctl.commit = 1'b1;
      ctl.status = okvt_pkg::ST_DONE;
      case (cmd_r)
        okvt_pkg::CMD_INSERT: begin
          if (stat.found) begin
            ctl.status = okvt_pkg::ST_PRESENT;
          end else if (stat.full) begin
            ctl.status = okvt_pkg::ST_FULL;
          end else begin
            ctl.append = 1'b1;
          end
        end
        okvt_pkg::CMD_UPDATE: begin
          if (stat.found) begin
            ctl.update = 1'b1;
          end else begin
            ctl.status = okvt_pkg::ST_ABSENT;
          end
        end
        okvt_pkg::CMD_INS_UPDATE: begin
          if (stat.found) begin
            ctl.update = 1'b1;
          end else if (stat.full) begin
            ctl.status = okvt_pkg::ST_FULL;
          end else begin
            ctl.append = 1'b1;
          end
        end
        okvt_pkg::CMD_ERASE: begin
          if (stat.found) begin
            ctl.erase = 1'b1;
          end else begin
            ctl.status = okvt_pkg::ST_ABSENT;
          end
        end
        okvt_pkg::CMD_LOOKUP: begin
          if (stat.found) begin
            ctl.val_en = 1'b1;
          end else begin
            ctl.status = okvt_pkg::ST_ABSENT;
          end
        end
        okvt_pkg::CMD_READ_AT: begin
          ctl.sel_pos = 1'b1;
          if (stat.pos_ok) begin
            ctl.key_en = 1'b1;
            ctl.val_en = 1'b1;
          end else begin
            ctl.status = okvt_pkg::ST_RANGE;
          end
        end
        default: begin
          ctl.status = okvt_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_command;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted beat did not move controller to exec");

  a_commit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> (!out_valid_r || out_ready))
    else $error("result committed over an untaken result");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EXEC)
    else $error("result raised without an executed command");

endmodule

@@ hw/rtl/okvt_dp.sv @@
// okvt_dp: entry cells with parallel key compare, tail append, one-step erase
// shift, entry count and the result register
// depends on okvt_pkg
module okvt_dp #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [okvt_pkg::KEY_W-1:0]      in_key,
  input  logic [okvt_pkg::VALUE_W-1:0]    in_value,
  input  logic [okvt_pkg::POS_W-1:0]      in_pos,
  input  okvt_pkg::okvt_ctl_t             ctl,
  output okvt_pkg::okvt_stat_t            stat,
  output logic [okvt_pkg::STATUS_W-1:0]   res_status,
  output logic [okvt_pkg::KEY_W-1:0]      res_key,
  output logic [okvt_pkg::VALUE_W-1:0]    res_value,
  output logic [okvt_pkg::USED_W-1:0]     res_used
);

  localparam int KW  = (KEY_BITS < okvt_pkg::KEY_W) ? KEY_BITS : okvt_pkg::KEY_W;
  localparam int VW  = (VALUE_BITS < okvt_pkg::VALUE_W) ? VALUE_BITS : okvt_pkg::VALUE_W;
  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int PXW = (IW > okvt_pkg::POS_W) ? IW : okvt_pkg::POS_W;

  logic [KW-1:0]                  key_r;
  logic [VW-1:0]                  val_r;
  logic [okvt_pkg::POS_W-1:0]     pos_r;
  logic [KW-1:0]                  keys_r [TABLE_DEPTH];
  logic [VW-1:0]                  vals_r [TABLE_DEPTH];
  logic [CW-1:0]                  count_r, count_nxt;
  logic [TABLE_DEPTH-1:0]         match;
  logic [IW-1:0]                  match_idx;
  logic [PXW-1:0]                 pos_x;
  logic [IW-1:0]                  pos_idx;
  logic [IW-1:0]                  sel_idx;
  logic [okvt_pkg::STATUS_W-1:0]  status_r;
  logic [okvt_pkg::KEY_W-1:0]     rkey_r;
  logic [okvt_pkg::VALUE_W-1:0]   rval_r;
  logic [okvt_pkg::USED_W-1:0]    used_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= KW'(in_key);
      val_r <= VW'(in_value);
      pos_r <= in_pos;
    end
  end

  // parallel compare, only cells below the count take part
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CW'(i) < count_r) && (keys_r[i] == key_r);
    end
  end

  always_comb begin
    match_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match[i]) begin
        match_idx = match_idx | IW'(i);
      end
    end
  end

  assign pos_x   = PXW'(pos_r);
  assign pos_idx = pos_x[IW-1:0];
  assign sel_idx = ctl.sel_pos ? pos_idx : match_idx;

  assign stat.found  = |match;
  assign stat.full   = (count_r == CW'(TABLE_DEPTH));
  assign stat.pos_ok = (32'(pos_r) < 32'(count_r));

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      always_ff @(posedge clk) begin
        if (ctl.append && (CW'(g) == count_r)) begin
          keys_r[g] <= key_r;
          vals_r[g] <= val_r;
        end else if (ctl.update && match[g]) begin
          vals_r[g] <= val_r;
        end else if (ctl.erase && (IW'(g) >= match_idx)) begin
          if (g < TABLE_DEPTH - 1) begin
            keys_r[g] <= keys_r[(g + 1) % TABLE_DEPTH];
            vals_r[g] <= vals_r[(g + 1) % TABLE_DEPTH];
          end
        end
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.append) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.erase) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status_r <= ctl.status;
      rkey_r   <= ctl.key_en ? okvt_pkg::KEY_W'(keys_r[pos_idx]) : '0;
      rval_r   <= ctl.val_en ? okvt_pkg::VALUE_W'(vals_r[sel_idx]) : '0;
      used_r   <= okvt_pkg::USED_W'(count_nxt);
    end
  end

  assign res_status = status_r;
  assign res_key    = rkey_r;
  assign res_value  = rval_r;
  assign res_used   = used_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key matches more than one live entry");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.append |-> (count_r < CW'(TABLE_DEPTH)) && !stat.found)
    else $error("append into a full table or of a present key");

endmodule

@@ hw/rtl/ordered_key_value_table.sv @@
// ordered_key_value_table: a beat is taken only while the controller is idle;
// in exec it runs the compare across all entry cells and commits the operation,
// stalling while an untaken result still holds the output register
// a finished result waits in the output register while the next beat is taken
// reset (rst_n low, synchronous) empties the table and clears the handshake;
// entry storage is not cleared, entries above the count are never read
module ordered_key_value_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // key [31:0], value [63:32], position [67:64], zero [71:68]
  input  logic [okvt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // command [2:0]
  input  logic [okvt_pkg::CMD_W-1:0]          in_tuser,
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // key_out [31:0], value_out [63:32], entries_used [68:64], zero [71:69]
  output logic [okvt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status [2:0]
  output logic [okvt_pkg::STATUS_W-1:0]       out_tuser
);

  okvt_pkg::okvt_ctl_t              ctl;
  okvt_pkg::okvt_stat_t             stat;
  logic [okvt_pkg::KEY_W-1:0]       res_key;
  logic [okvt_pkg::VALUE_W-1:0]     res_value;
  logic [okvt_pkg::USED_W-1:0]      res_used;

  // controller: beat handshake, command decode, result handshake
  okvt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_command (in_tuser),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  // datapath: entry cells, count and result register
  okvt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_key     (in_tdata[31:0]),
    .in_value   (in_tdata[63:32]),
    .in_pos     (in_tdata[67:64]),
    .ctl        (ctl),
    .stat       (stat),
    .res_status (out_tuser),
    .res_key    (res_key),
    .res_value  (res_value),
    .res_used   (res_used)
  );

  // pack the result beat, padding bits stay zero
  assign out_tdata = {3'b000, res_used, res_value, res_key};

endmodule
